// ----- design/srs_pkg.sv -----
package srs_pkg;

  localparam int PAT_MAX    = 8;
  localparam int REPL_MAX   = 8;
  localparam int RES_MAX    = 8;
  localparam int RES_CNT_W  = 4;
  localparam int RES_IDX_W  = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam int CHAR_W     = 8;
  localparam int LEN_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 3'd3;

  // One item's worth of result bytes, handed from the front end to the back end.
  typedef struct packed {
    logic [RES_MAX-1:0][CHAR_W-1:0] bytes;
    logic [RES_CNT_W-1:0]           cnt;
    logic                           last;
  } srs_job_t;

  // A length of zero counts as one, and a length above the maximum as the maximum.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw,
                                               input logic [LEN_W-1:0] maxv);
    logic [LEN_W-1:0] v;
    v = (raw == '0) ? LEN_W'(1) : raw;
    if (v > maxv) v = maxv;
    return v;
  endfunction

endpackage

// ----- design/srs_front.sv -----
module srs_front
  import srs_pkg::*;
#(
  parameter int MAX_PATTERN     = PAT_MAX,
  parameter int MAX_REPLACEMENT = REPL_MAX
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CHAR_W-1:0]     in_char_in,
  input  logic                  in_end_in,
  output logic                  push_valid,
  input  logic                  push_ready,
  output srs_job_t              push_job
);

  localparam int CW    = $clog2(MAX_PATTERN + 1);
  localparam int SUM_W = $clog2(MAX_PATTERN + MAX_REPLACEMENT + 1);

  logic [CFG_DATA_W-1:0] pat_bytes_r;
  logic [LEN_W-1:0]      pat_len_r;
  logic [CFG_DATA_W-1:0] repl_bytes_r;
  logic [LEN_W-1:0]      repl_len_r;

  logic [CHAR_W-1:0] win_r [MAX_PATTERN];
  logic [CW-1:0]     wcnt_r;

  logic [CHAR_W-1:0] w_ext   [MAX_PATTERN];
  logic [CHAR_W-1:0] w_shift [MAX_PATTERN];
  logic [MAX_PATTERN:0] ok;
  logic [CW-1:0]     n_new;
  logic [CW-1:0]     shift;
  logic [CW-1:0]     wcnt_nxt;
  logic [LEN_W-1:0]  plen;
  logic [LEN_W-1:0]  rlen;
  logic              match;
  logic [SUM_W-1:0]  sum;
  logic [RES_IDX_W-1:0] ridx;
  logic              accept;

  assign plen = eff_len(pat_len_r, LEN_W'(MAX_PATTERN));
  assign rlen = eff_len(repl_len_r, LEN_W'(MAX_REPLACEMENT));

  // The new byte lands after the pending window; then every possible shift is
  // tested at once and the smallest one that leaves a pattern prefix wins.
  always_comb begin
    int k;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      w_ext[i] = (i == int'(wcnt_r)) ? in_char_in : win_r[i];
    end
    n_new = wcnt_r + 1'b1;

    for (int s = 0; s <= MAX_PATTERN; s++) begin
      ok[s] = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (s + i < int'(n_new)) begin
          if (s + i >= MAX_PATTERN) begin
            ok[s] = 1'b0;
          end else if (w_ext[s+i] != pat_bytes_r[CHAR_W*i +: CHAR_W]) begin
            ok[s] = 1'b0;
          end
        end
      end
    end

    shift = '0;
    for (int s = MAX_PATTERN; s >= 0; s--) begin
      if (ok[s]) shift = CW'(s);
    end

    // Only an unshifted window can be a whole pattern.
    match = (shift == '0) && (LEN_W'(n_new) == plen);

    ridx = '0;
    for (int j = 0; j < RES_MAX; j++) begin
      if (match && (j >= int'(shift))) begin
        ridx = RES_IDX_W'(j - int'(shift));
        push_job.bytes[j] = repl_bytes_r[CHAR_W*ridx +: CHAR_W];
      end else if (j < MAX_PATTERN) begin
        push_job.bytes[j] = w_ext[j];
      end else begin
        push_job.bytes[j] = '0;
      end
    end

    sum = SUM_W'(shift) + SUM_W'(rlen);
    if (match) begin
      push_job.cnt = (sum > SUM_W'(RES_MAX)) ? RES_CNT_W'(RES_MAX) : RES_CNT_W'(sum);
    end else if (in_end_in) begin
      push_job.cnt = RES_CNT_W'(n_new);
    end else begin
      push_job.cnt = RES_CNT_W'(shift);
    end
    push_job.last = in_end_in;

    for (int i = 0; i < MAX_PATTERN; i++) begin
      k = i + int'(shift);
      w_shift[i] = (k < MAX_PATTERN) ? w_ext[k] : '0;
    end
    wcnt_nxt = (match || in_end_in) ? '0 : CW'(n_new - shift);
  end

  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = in_valid && (push_job.cnt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_bytes_r  <= '0;
      pat_len_r    <= LEN_W'(1);
      repl_bytes_r <= '0;
      repl_len_r   <= LEN_W'(1);
      wcnt_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_BYTES: begin
          pat_bytes_r <= cfg_wdata;
          wcnt_r      <= '0;
        end
        CFG_PATTERN_LENGTH: begin
          pat_len_r <= cfg_wdata[LEN_W-1:0];
          wcnt_r    <= '0;
        end
        CFG_REPLACEMENT_BYTES: begin
          repl_bytes_r <= cfg_wdata;
          wcnt_r       <= '0;
        end
        CFG_REPLACEMENT_LENGTH: begin
          repl_len_r <= cfg_wdata[LEN_W-1:0];
          wcnt_r     <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      wcnt_r <= wcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        win_r[i] <= w_shift[i];
      end
    end
  end

  // The pending window is always a proper prefix of the pattern.
  a_window_short: assert property (@(posedge clk) disable iff (!rst_n)
    LEN_W'(wcnt_r) < plen)
    else $error("pending window reached the pattern length");

endmodule

// ----- design/srs_queue.sv -----
module srs_queue
  import srs_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  srs_job_t push_job,
  output logic     pop_valid,
  input  logic     pop_ready,
  output srs_job_t pop_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  srs_job_t      entries_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          push;
  logic          pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue fill count beyond its depth");

endmodule

// ----- design/srs_back.sv -----
module srs_back
  import srs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  srs_job_t          q_job,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char_out,
  output logic              out_end_out,
  output logic              out_run_done
);

  srs_job_t             cur_r;
  logic [RES_CNT_W-1:0] idx_r;
  logic                 busy_r;
  logic                 out_valid_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic                 out_end_r;
  logic                 out_done_r;
  logic                 adv;
  logic                 at_end;

  // A byte moves into the output register whenever that register is free or drained.
  assign adv     = busy_r && (!out_valid_r || out_ready);
  assign at_end  = (RES_CNT_W'(idx_r + 1'b1) == cur_r.cnt);
  assign q_ready = !busy_r || (adv && at_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_valid && q_ready) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (adv && at_end) begin
        busy_r <= 1'b0;
      end else if (adv) begin
        idx_r <= idx_r + 1'b1;
      end

      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      cur_r <= q_job;
    end
    if (adv) begin
      out_char_r <= cur_r.bytes[idx_r[RES_IDX_W-1:0]];
      out_end_r  <= cur_r.last && at_end;
      out_done_r <= at_end;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;
  assign out_end_out  = out_end_r;
  assign out_run_done = out_done_r;

  a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cur_r.cnt != '0))
    else $error("back end busy with an empty item");

  a_end_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_end_r) |-> out_done_r)
    else $error("end of string flagged on a byte that does not close its item");

endmodule

// ----- design/substring_replace_stream.sv -----
// Streaming find-and-replace: every leftmost, non-overlapping occurrence of the
// configured pattern (1 to MAX_PATTERN bytes) in the byte stream is replaced by
// the configured replacement (1 to MAX_REPLACEMENT bytes); other bytes pass
// through, and the pending partial match is flushed on the byte marked end_in.
// The front end takes one item per cycle while the queue has room, and checks
// all window shifts in that cycle with a bank of parallel byte comparators; it
// hands the bytes an item produces (at most eight) through a QUEUE_DEPTH-entry
// queue to the back end, which sends one byte per cycle from its output register
// while out_ready holds. Sustained throughput is set by the single-byte output
// port; an item that yields no byte is not queued. Write configuration only
// while the block is idle; any write to one of the four configuration indices
// drops the pending window bytes.
module substring_replace_stream
  import srs_pkg::*;
#(
  parameter int MAX_PATTERN     = PAT_MAX,
  parameter int MAX_REPLACEMENT = REPL_MAX,
  parameter int QUEUE_DEPTH     = srs_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CHAR_W-1:0]     in_char_in,
  input  logic                  in_end_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAR_W-1:0]     out_char_out,
  output logic                  out_end_out,
  output logic                  out_run_done
);

  logic     push_valid;
  logic     push_ready;
  srs_job_t push_job;
  logic     pop_valid;
  logic     pop_ready;
  srs_job_t pop_job;

  srs_front #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_char_in (in_char_in),
    .in_end_in  (in_end_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  srs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  srs_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (pop_valid),
    .q_ready      (pop_ready),
    .q_job        (pop_job),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_out (out_char_out),
    .out_end_out  (out_end_out),
    .out_run_done (out_run_done)
  );

endmodule
